/* src/hsp_pkg.sv */
// Shared types and constants for the hashed server placement block.
`timescale 1ns / 1ps
`default_nettype none
package hsp_pkg;

  localparam int CS_W    = 7;
  localparam int NSRV_W  = 7;
  localparam int CAP_W   = 8;
  localparam int SRV_W   = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [CS_W-1:0] CH_SPACE = 7'h20;
  localparam logic [31:0] MUL_HOME = 32'd7919;
  localparam logic [31:0] MUL_STEP = 32'd104279;
  localparam logic [31:0] ADD_STEP = 32'd123;

  localparam logic [CFG_IDX_W-1:0] REG_SRV_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CAP   = 1'd1;

  localparam logic [NSRV_W-1:0] SRV_COUNT_RST = 7'd1;
  localparam logic [CAP_W-1:0]  MAX_CAP_RST   = 8'd1;

  typedef struct packed {
    logic [CS_W-1:0] ch;
    logic            last;
  } in_item_t;

  typedef struct packed {
    logic [SRV_W-1:0] first_server;
    logic [SRV_W-1:0] final_server;
    logic             moved;
    logic [CAP_W-1:0] new_count;
    logic             failed;
  } out_item_t;

  typedef struct packed {
    logic [NSRV_W-1:0] srv_count;
    logic [CAP_W-1:0]  max_cap;
  } cfg_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage
`default_nettype wire

/* src/hsp_fifo.sv */
// Small register queue used between the front and back and at the result side.
`timescale 1ns / 1ps
`default_nettype none
module hsp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

/* src/hsp_front.sv */
// Front end: folds key characters into the checksum and queues finished keys.
`timescale 1ns / 1ps
`default_nettype none
module hsp_front
  import hsp_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire in_item_t        in_item,
  output logic                 q_push,
  output logic      [CS_W-1:0] q_data
);

  logic [CS_W-1:0] cs;
  logic [CS_W-1:0] cs_next;

  always_comb begin
    cs_next = (in_item.ch == CH_SPACE) ? cs : (cs ^ in_item.ch);
  end

  assign q_push = accept && in_item.last;
  assign q_data = cs_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cs <= '0;
    end else if (accept) begin
      cs <= in_item.last ? '0 : cs_next;
    end
  end

endmodule
`default_nettype wire

/* src/hsp_back.sv */
// Back end: hashes a key checksum, walks the probe sequence and updates occupancy.
`timescale 1ns / 1ps
`default_nettype none
module hsp_back
  import hsp_pkg::*;
#(
  parameter int SERVERS_MAX = 64,
  parameter int PROBE_LIMIT = 256
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cfg_t            cfg,
  input  wire logic            q_empty,
  input  wire logic [CS_W-1:0] q_data,
  output logic                 q_pop,
  input  wire logic            o_full,
  output logic                 o_push,
  output out_item_t            o_data,
  output back_status_t         stat
);

  localparam int IDX_W = (SERVERS_MAX > 1) ? $clog2(SERVERS_MAX) : 1;
  localparam int NMAX  = (SERVERS_MAX < 127) ? SERVERS_MAX : 127;
  localparam int PI_W  = $clog2(PROBE_LIMIT + 1);
  localparam int LANES = 3;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;

  logic [2:0]        state;
  logic [IDX_W-1:0]  clr_cnt;
  logic [4:0]        div_cnt;
  logic [NSRV_W-1:0] rem [LANES];
  logic [31:0]       sh  [LANES];
  logic [NSRV_W-1:0] rem_div [LANES];
  logic [NSRV_W:0]   trial [LANES];
  logic [31:0]       v;
  logic [31:0]       step;
  logic [NSRV_W-1:0] home;
  logic [NSRV_W-1:0] w;
  logic [PI_W-1:0]   probe_i;
  logic [CAP_W-1:0]  home_cnt;
  logic [CAP_W-1:0]  counts [SERVERS_MAX];
  logic [CAP_W-1:0]  rd_data;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic [CAP_W-1:0]  wr_data;
  logic              wr_en;
  logic [NSRV_W-1:0] n;
  logic [31:0]       prod_home;
  logic [31:0]       prod_step;
  logic [NSRV_W:0]   sum;
  logic [NSRV_W-1:0] r1;
  logic [32:0]       vsum;
  logic [NSRV_W-1:0] r_next;
  logic              is_full;
  logic              at_limit;

  // Effective server count: zero acts as one, large values clamp to the table size.
  always_comb begin
    if (cfg.srv_count == '0) begin
      n = NSRV_W'(1);
    end else if (cfg.srv_count > NSRV_W'(NMAX)) begin
      n = NSRV_W'(NMAX);
    end else begin
      n = cfg.srv_count;
    end
  end

  assign prod_home = MUL_HOME * {25'd0, q_data};
  assign prod_step = MUL_STEP * {25'd0, q_data} + ADD_STEP;

  // One restoring division step per cycle in each lane, all by the same modulus.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      trial[k] = {rem[k], sh[k][31]};
      rem_div[k] = (trial[k] >= {1'b0, n}) ? NSRV_W'(trial[k] - {1'b0, n})
                                           : trial[k][NSRV_W-1:0];
    end
  end

  // Next probe index from the current one: add the step residue, and when the
  // 32-bit sum wraps take away the residue of two to the 32nd.
  always_comb begin
    sum  = {1'b0, rem[0]} + {1'b0, rem[1]};
    r1   = (sum >= {1'b0, n}) ? NSRV_W'(sum - {1'b0, n}) : sum[NSRV_W-1:0];
    vsum = {1'b0, v} + {1'b0, step};
    if (!vsum[32]) begin
      r_next = r1;
    end else if (r1 >= w) begin
      r_next = r1 - w;
    end else begin
      r_next = NSRV_W'({1'b0, r1} + {1'b0, n} - {1'b0, w});
    end
  end

  assign is_full  = (rd_data >= cfg.max_cap);
  assign at_limit = (probe_i == PI_W'(PROBE_LIMIT));
  assign rd_addr  = IDX_W'(rem[0]);
  assign q_pop    = (state == S_IDLE) && !q_empty && !o_full;
  assign stat.clearing = (state == S_CLEAR);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr;
    wr_data = rd_data + 1'b1;
    o_push  = 1'b0;
    o_data.first_server = home[SRV_W-1:0];
    o_data.final_server = rem[0][SRV_W-1:0];
    o_data.moved        = (probe_i != '0);
    o_data.new_count    = rd_data + 1'b1;
    o_data.failed       = 1'b0;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '0;
    end else if (state == S_CHECK) begin
      if (!is_full) begin
        wr_en  = 1'b1;
        o_push = 1'b1;
      end else if (at_limit) begin
        o_push = 1'b1;
        o_data.final_server = home[SRV_W-1:0];
        o_data.moved        = 1'b1;
        o_data.new_count    = home_cnt;
        o_data.failed       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      counts[wr_addr] <= wr_data;
    end
    rd_data <= counts[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (clr_cnt == IDX_W'(SERVERS_MAX - 1)) begin
            state <= S_IDLE;
          end
          clr_cnt <= clr_cnt + 1'b1;
        end
        S_IDLE: begin
          if (q_pop) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt == 5'd31) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          state <= S_READ;
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          state <= (!is_full || at_limit) ? S_IDLE : S_READ;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        v       <= prod_home;
        step    <= prod_step;
        sh[0]   <= prod_home;
        sh[1]   <= prod_step;
        sh[2]   <= '1;
        div_cnt <= '0;
        for (int k = 0; k < LANES; k++) begin
          rem[k] <= '0;
        end
      end
      S_DIV: begin
        div_cnt <= div_cnt + 1'b1;
        for (int k = 0; k < LANES; k++) begin
          rem[k] <= rem_div[k];
          sh[k]  <= {sh[k][30:0], 1'b0};
        end
      end
      S_PREP: begin
        home    <= rem[0];
        probe_i <= '0;
        w <= ({1'b0, rem[2]} + 1'b1 == {1'b0, n}) ? '0 : rem[2] + 1'b1;
      end
      S_CHECK: begin
        if (probe_i == '0) begin
          home_cnt <= rd_data;
        end
        if (is_full && !at_limit) begin
          probe_i <= probe_i + 1'b1;
          v       <= vsum[31:0];
          rem[0]  <= r_next;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/hashed_server_placement.sv */
// Input: a character without the last flag is absorbed at one item per cycle while full is low.
// A key's last character queues its checksum for the back end, where a bit-serial modulo
// unit hashes it and each probe past home costs one occupancy memory read and one compare.
// The back end takes a new key only once it has finished with the last one.
// Reset: synchronous, active high; afterwards a clearing pass zeroes the occupancy
// memory, and full stays high until it is done.
`timescale 1ns / 1ps
`default_nettype none
module hashed_server_placement
  import hsp_pkg::*;
#(
  parameter int SERVERS_MAX = 64,
  parameter int PROBE_LIMIT = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire in_item_t             in_item,
  output logic                      empty,
  input  wire logic                 pop,
  output out_item_t                 out_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CAP_W-1:0]     cfg_data
);

  localparam int OUT_W = $bits(out_item_t);

  cfg_t             cfg;
  back_status_t     stat;
  logic             accept;
  logic             q_push;
  logic [CS_W-1:0]  q_wdata;
  logic [CS_W-1:0]  q_rdata;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic             o_push;
  out_item_t        o_data;
  logic             o_full;
  logic [OUT_W-1:0] o_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.srv_count <= SRV_COUNT_RST;
      cfg.max_cap   <= MAX_CAP_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_SRV_COUNT) begin
        cfg.srv_count <= cfg_data[NSRV_W-1:0];
      end
      if (cfg_index == REG_MAX_CAP) begin
        cfg.max_cap <= cfg_data;
      end
    end
  end

  assign full   = q_full || stat.clearing;
  assign accept = push && !full;

  hsp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_item (in_item),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  hsp_fifo #(
    .WIDTH (CS_W),
    .DEPTH (2)
  ) u_key_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  hsp_back #(
    .SERVERS_MAX (SERVERS_MAX),
    .PROBE_LIMIT (PROBE_LIMIT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .o_full  (o_full),
    .o_push  (o_push),
    .o_data  (o_data),
    .stat    (stat)
  );

  hsp_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (o_push),
    .wdata (o_data),
    .pop   (pop),
    .rdata (o_rdata),
    .full  (o_full),
    .empty (empty)
  );

  assign out_item = out_item_t'(o_rdata);

endmodule
`default_nettype wire

/* src/hsp_checker.sv */
// Port-level checks for the hashed server placement block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module hsp_checker
  import hsp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      full,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_item_t out_item
);

  // Reset drops any waiting result and blocks input until the occupancy counts are cleared.
  a_reset_state: assert property (@(posedge clk) rst |=> empty && full)
    else $error("reset did not empty the result side and raise full");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed before it was taken");

  a_fail_moved: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.failed) |-> (out_item.moved &&
      out_item.first_server == out_item.final_server))
    else $error("failed item not marked as moved to its home server");

  a_home_taken: assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_item.moved) |-> (!out_item.failed &&
      out_item.first_server == out_item.final_server && out_item.new_count != '0))
    else $error("unmoved item not placed on its home server");

endmodule

bind hashed_server_placement hsp_checker u_hsp_checker (.*);
`default_nettype wire
